[rtl/pfkmq_pkg.sv]
// Package: shared constants and transaction types for the prime-factor keyed min/max queue.
package pfkmq_pkg;

	localparam int CAPACITY_DEF   = 256;
	localparam int VALUE_BITS_DEF = 20;
	localparam int NUM_W          = 20;
	localparam int CNT_W          = 3;

	localparam logic [1:0] ST_PAIR   = 2'd0;
	localparam logic [1:0] ST_SINGLE = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;

	typedef struct packed {
		logic [NUM_W-1:0] value;
		logic             group_end;
	} in_item_t;

	typedef struct packed {
		logic [NUM_W-1:0] top_number;
		logic [NUM_W-1:0] bottom_number;
		logic [1:0]       status;
		logic             insert_dropped;
	} out_item_t;

endpackage

[rtl/prime_factor_keyed_minmax_queue.sv]
// Top level: counts distinct prime factors by trial division, keeps a keyed set in a memory.
// Count is zero if no trial divisor divides. Per trial divisor, while its square is at most the
// remaining value: a test, 20 one-bit divide steps, a check; a found factor is divided out again.
// Then scan and insert; a group end adds a min/max scan and removal, then done pulses.
// No new transaction is taken until idle again, busy high throughout; the receiver cannot stall.
// Reset: valid bits, occupancy, drop flag and sequencer clear asynchronously; store is not cleared.
module prime_factor_keyed_minmax_queue #(
	parameter int CAPACITY = pfkmq_pkg::CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  pfkmq_pkg::in_item_t   in_item,
	output logic                  busy,
	output logic                  done,
	output pfkmq_pkg::out_item_t  out_item
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int NW = pfkmq_pkg::NUM_W;
	localparam int CW = pfkmq_pkg::CNT_W;
	localparam int EW = CW + NW;

	typedef enum logic [3:0] {
		S_IDLE, S_DTEST, S_DIV, S_DIVSTEP, S_SCAN, S_SCANW, S_INS, S_MM, S_MMW, S_REM, S_OUT
	} state_t;

	state_t state_q;

	// store
	logic [EW-1:0]       mem [CAPACITY];
	logic [CAPACITY-1:0] vld_q;
	logic [EW-1:0]       rd_q;
	logic [AW:0]         occ_q;
	logic                drop_q;

	// factoring
	logic [NW-1:0] v_q, n_q, d_q, rem_q, quo_q;
	logic [4:0]    bit_q;
	logic [CW-1:0] cnt_q;
	logic          divided_q, hit_q, end_q;
	// scan
	logic [AW:0]   idx_q;
	logic [AW-1:0] ra_q;
	logic          present_q, free_ok_q;
	logic [AW-1:0] free_q;
	logic          have_q;
	logic [AW-1:0] hi_q, lo_q;
	logic [EW-1:0] hik_q, lok_q;

	// shared restoring divide step: n_q / d_q, one quotient bit a cycle
	logic [NW:0]   trial;
	logic [NW-1:0] rem_sh;
	assign rem_sh = {rem_q[NW-2:0], n_q[bit_q]};
	assign trial  = {1'b0, rem_sh} - {1'b0, d_q};

	logic [2*NW-1:0] dsq;
	assign dsq = d_q * d_q;

	logic [AW-1:0] ia;
	assign ia = idx_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (state_q == S_INS && !present_q && free_ok_q)
			mem[free_q] <= {cnt_q, v_q};
		rd_q <= mem[ra_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q   <= '0;
			occ_q   <= '0;
			drop_q  <= 1'b0;
			done    <= 1'b0;
			busy    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						v_q       <= in_item.value;
						n_q       <= in_item.value;
						end_q     <= in_item.group_end;
						d_q       <= NW'(2);
						cnt_q     <= '0;
						divided_q <= 1'b0;
						busy      <= 1'b1;
						state_q   <= S_DTEST;
					end
				end
				S_DTEST: begin
					if ({{NW{1'b0}}, n_q} < dsq) begin
						if (n_q > NW'(1))
							cnt_q <= cnt_q + CW'(1);
						state_q <= S_SCAN;
						idx_q   <= '0;
						ra_q    <= '0;
						present_q <= 1'b0;
						free_ok_q <= 1'b0;
					end else begin
						rem_q   <= '0;
						bit_q   <= 5'(NW-1);
						hit_q   <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (trial[NW]) begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end else begin
						rem_q <= trial[NW-1:0];
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end
					if (bit_q == 5'd0)
						state_q <= S_DIVSTEP;
					else
						bit_q <= bit_q - 5'd1;
				end
				S_DIVSTEP: begin
					if (rem_q == '0) begin
						// divisible: drop factor and divide again by the same d
						if (!hit_q) begin
							cnt_q     <= cnt_q + CW'(1);
							divided_q <= 1'b1;
						end
						n_q     <= quo_q;
						rem_q   <= '0;
						bit_q   <= 5'(NW-1);
						hit_q   <= 1'b1;
						state_q <= S_DIV;
					end else begin
						d_q     <= d_q + NW'(1);
						state_q <= S_DTEST;
					end
				end
				S_SCAN: begin
					if (!divided_q)
						cnt_q <= '0;
					ra_q    <= ia + AW'(1);
					state_q <= S_SCANW;
				end
				S_SCANW: begin
					if (vld_q[ia]) begin
						if (rd_q[NW-1:0] == v_q)
							present_q <= 1'b1;
					end else if (!free_ok_q) begin
						free_ok_q <= 1'b1;
						free_q    <= ia;
					end
					if (idx_q == (AW+1)'(CAPACITY-1)) begin
						state_q <= S_INS;
					end else begin
						idx_q <= idx_q + (AW+1)'(1);
						ra_q  <= ia + AW'(2);
						state_q <= S_SCANW;
					end
				end
				S_INS: begin
					if (!present_q) begin
						if (free_ok_q) begin
							vld_q[free_q] <= 1'b1;
							occ_q         <= occ_q + (AW+1)'(1);
						end else
							drop_q <= 1'b1;
					end
					if (end_q) begin
						idx_q   <= '0;
						ra_q    <= '0;
						have_q  <= 1'b0;
						state_q <= S_MM;
					end else begin
						busy    <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_MM: begin
					ra_q    <= AW'(1);
					state_q <= S_MMW;
				end
				S_MMW: begin
					if (vld_q[ia]) begin
						if (!have_q || rd_q > hik_q) begin
							hik_q <= rd_q;
							hi_q  <= ia;
						end
						if (!have_q || rd_q < lok_q) begin
							lok_q <= rd_q;
							lo_q  <= ia;
						end
						have_q <= 1'b1;
					end
					if (idx_q == (AW+1)'(CAPACITY-1))
						state_q <= S_REM;
					else begin
						idx_q <= idx_q + (AW+1)'(1);
						ra_q  <= ia + AW'(2);
					end
				end
				S_REM: begin
					out_item.insert_dropped <= drop_q;
					drop_q <= 1'b0;
					if (!have_q) begin
						out_item.top_number    <= '0;
						out_item.bottom_number <= '0;
						out_item.status        <= pfkmq_pkg::ST_EMPTY;
					end else begin
						out_item.top_number    <= hik_q[NW-1:0];
						out_item.bottom_number <= lok_q[NW-1:0];
						vld_q[hi_q] <= 1'b0;
						vld_q[lo_q] <= 1'b0;
						if (hi_q == lo_q) begin
							out_item.status <= pfkmq_pkg::ST_SINGLE;
							occ_q <= occ_q - (AW+1)'(1);
						end else begin
							out_item.status <= pfkmq_pkg::ST_PAIR;
							occ_q <= occ_q - (AW+1)'(2);
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					done    <= 1'b1;
					busy    <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
